>>> hdl/qpv_pkg.sv
// Shared types, constants and the quadrature step decode for the position/velocity block.
package qpv_pkg;

  // Field and datapath widths
  localparam int unsigned CPR_W      = 16;
  localparam int unsigned PERIOD_W   = 24;
  localparam int unsigned FIX_W      = 48;
  localparam int unsigned DEN_W      = CPR_W + PERIOD_W;
  localparam int unsigned COUNT_OUT_W = 32;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = COUNT_OUT_W + 2 * FIX_W;

  // Default count width and register reset
  localparam int unsigned COUNT_WIDTH_DEF = 32;
  localparam logic [CPR_W-1:0] CPR_RESET = 16'd2048;

  // Fixed-point scaling: 1e6 * 2^16 = 15625 * 2^22
  localparam int unsigned SCALE_W   = 14;
  localparam logic [SCALE_W-1:0] VEL_SCALE = 14'd15625;
  localparam int unsigned POS_SHIFT = 16;
  localparam int unsigned VEL_SHIFT = 22;
  // Extra dividend bits over the count width: scale, shift and rounding carry
  localparam int unsigned DIV_EXTRA = SCALE_W + VEL_SHIFT + 1;

  // Item kinds carried in the input tuser
  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_UPDATE = 2'd1,
    OP_ZERO   = 2'd2
  } op_e;

  // Transition codes {previous A, previous B, new A, new B}
  localparam logic [3:0] FWD_0 = 4'b1101;
  localparam logic [3:0] FWD_1 = 4'b0100;
  localparam logic [3:0] FWD_2 = 4'b0010;
  localparam logic [3:0] FWD_3 = 4'b1011;
  localparam logic [3:0] REV_0 = 4'b1110;
  localparam logic [3:0] REV_1 = 4'b0111;
  localparam logic [3:0] REV_2 = 4'b0001;
  localparam logic [3:0] REV_3 = 4'b1000;

  typedef enum logic [1:0] {
    STEP_HOLD = 2'd0,
    STEP_UP   = 2'd1,
    STEP_DOWN = 2'd2
  } step_e;

  // Decode one pin transition into a count direction
  function automatic step_e qpv_step(input logic [3:0] trans);
    step_e dir;
    dir = STEP_HOLD;
    case (trans) inside
      FWD_0, FWD_1, FWD_2, FWD_3: dir = STEP_UP;
      REV_0, REV_1, REV_2, REV_3: dir = STEP_DOWN;
      default:                    dir = STEP_HOLD;
    endcase
    return dir;
  endfunction

endpackage

>>> hdl/qpv_divider.sv
// Bit-serial restoring divider with rounding-aware saturation to a signed Q31.16 result.
module qpv_divider #(
  parameter int unsigned DivW = qpv_pkg::COUNT_WIDTH_DEF + qpv_pkg::DIV_EXTRA
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [DivW-1:0]             dividend_i,
  input  logic [qpv_pkg::DEN_W-1:0]   divisor_i,
  input  logic                        neg_i,
  output logic                        done_o,
  output logic [qpv_pkg::FIX_W-1:0]   result_o
);
  import qpv_pkg::*;

  localparam int unsigned CntW = $clog2(DivW + 1);

  logic [DivW-1:0]  dvd_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q;
  logic [FIX_W:0]   quot_q;
  logic             ovf_q;
  logic             neg_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fit;
  logic [FIX_W-1:0] lim;
  logic             big;
  logic [FIX_W-1:0] mag;

  // Trial subtract of the divisor from the shifted partial remainder
  assign trial = {rem_q, dvd_q[DivW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fit   = ~diff[DEN_W];

  // Sequence control: one quotient bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DivW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift dividend, restore remainder, collect quotient bits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q  <= dividend_i;
      den_q  <= divisor_i;
      neg_q  <= neg_i;
      rem_q  <= '0;
      quot_q <= '0;
      ovf_q  <= 1'b0;
    end else if (busy_q) begin
      dvd_q  <= {dvd_q[DivW-2:0], 1'b0};
      rem_q  <= fit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quot_q <= {quot_q[FIX_W-1:0], fit};
      ovf_q  <= ovf_q | quot_q[FIX_W];
    end
  end

  // Clamp the magnitude to the signed range, then apply the sign
  always_comb begin
    lim = neg_q ? {1'b1, {(FIX_W-1){1'b0}}} : {1'b0, {(FIX_W-1){1'b1}}};
    big = ovf_q || (quot_q > {1'b0, lim});
    mag = big ? lim : quot_q[FIX_W-1:0];
    result_o = neg_q ? (~mag + FIX_W'(1)) : mag;
  end

  assign done_o = done_q;

endmodule

>>> hdl/quadrature_position_velocity.sv
// Top level of the x4 quadrature decoder with position and velocity scaling.
//
// Usage: each input beat on the s_axis channel carries one item; its kind sits in
// s_axis_tuser (0 pin sample, 1 periodic update, 2 zero the count). Every accepted
// beat yields exactly one output beat on m_axis with the count after the item, the
// latched position and velocity (signed Q31.16) and, in m_axis_tuser, a flag that
// is set when the item recomputed both latches.
// Pin samples, zero items and updates that change nothing need no division: the
// result shows in the cycle after acceptance, and such items are taken every cycle
// while m_axis_tready is high. An update with a nonzero period and counts_per_rev
// runs two divisions through one shared bit-serial divider, one quotient bit per
// cycle over COUNT_WIDTH+37 bits; s_axis_tready stays low meanwhile. The cfg
// channel writes counts_per_rev and is always ready; write it only while the block
// is idle.
// A result waits in the output register while m_axis_tready is low; a new item is
// accepted in the same cycle the waiting result is taken. Reset clears the count,
// the latches and the pin history and sets counts_per_rev to 2048.
module quadrature_position_velocity #(
  parameter int unsigned COUNT_WIDTH = qpv_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Input items
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [0] phase_a, [1] phase_b, [25:2] period_us, [31:26] zero
  input  logic [qpv_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [1:0] op
  input  logic [1:0]                       s_axis_tuser,
  // Results
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [31:0] count, [79:32] position_rev, [127:80] velocity_rps
  output logic [qpv_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // [0] updated
  output logic                             m_axis_tuser,
  // Configuration write: counts_per_rev
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [qpv_pkg::CPR_W-1:0]        cfg_data_i
);
  import qpv_pkg::*;

  localparam int unsigned CW    = COUNT_WIDTH;
  localparam int unsigned DivW  = COUNT_WIDTH + DIV_EXTRA;
  localparam int unsigned ProdW = COUNT_WIDTH + SCALE_W;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_POS_LOAD = 6'b000010,
    ST_POS_RUN  = 6'b000100,
    ST_VEL_MUL  = 6'b001000,
    ST_VEL_LOAD = 6'b010000,
    ST_VEL_RUN  = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [CPR_W-1:0]  cpr_q;
  logic [1:0]        last_ab_q, last_ab_d;
  logic              primed_q, primed_d;
  logic [CW-1:0]     pulse_q, pulse_d;
  logic [CW-1:0]     prior_q, prior_d;
  logic [FIX_W-1:0]  pos_q, pos_d;
  logic [FIX_W-1:0]  vel_q, vel_d;
  logic [CW-1:0]     delta_q, delta_d;
  logic [CW-1:0]     pos_mag_q, pos_mag_d;
  logic              pos_neg_q, pos_neg_d;
  logic [CW-1:0]     dmag_q, dmag_d;
  logic              vel_neg_q, vel_neg_d;
  logic [DEN_W-1:0]  den_q, den_d;
  logic [ProdW-1:0]  vprod_q, vprod_d;
  logic              out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic              out_user_q;

  logic              in_fire;
  op_e               op;
  logic [1:0]        ab;
  logic [PERIOD_W-1:0] period;
  logic              out_load;
  logic              upd;

  logic              div_start;
  logic [DivW-1:0]   div_dividend;
  logic [DEN_W-1:0]  div_divisor;
  logic              div_neg;
  logic              div_done;
  logic [FIX_W-1:0]  div_result;

  // Unpack the input beat
  assign op     = op_e'(s_axis_tuser);
  assign ab     = {s_axis_tdata[0], s_axis_tdata[1]};
  assign period = s_axis_tdata[PERIOD_W+1:2];

  // Accept only when idle and the output register frees up this cycle
  assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Item handling and update sequencer
  always_comb begin
    state_d   = state_q;
    last_ab_d = last_ab_q;
    primed_d  = primed_q;
    pulse_d   = pulse_q;
    prior_d   = prior_q;
    pos_d     = pos_q;
    vel_d     = vel_q;
    delta_d   = delta_q;
    pos_mag_d = pos_mag_q;
    pos_neg_d = pos_neg_q;
    dmag_d    = dmag_q;
    vel_neg_d = vel_neg_q;
    den_d     = den_q;
    vprod_d   = vprod_q;
    out_load  = 1'b0;
    upd       = 1'b0;
    div_start = 1'b0;
    div_dividend = DivW'({pos_mag_q, {POS_SHIFT{1'b0}}}) + DivW'(cpr_q >> 1);
    div_divisor  = DEN_W'(cpr_q);
    div_neg      = pos_neg_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (op)
            OP_SAMPLE: begin
              if (primed_q) begin
                unique case (qpv_step({last_ab_q, ab}))
                  STEP_UP:   pulse_d = pulse_q + CW'(1);
                  STEP_DOWN: pulse_d = pulse_q - CW'(1);
                  default:   pulse_d = pulse_q;
                endcase
              end
              last_ab_d = ab;
              primed_d  = 1'b1;
              out_load  = 1'b1;
            end
            OP_UPDATE: begin
              if ((period != '0) && (cpr_q != '0)) begin
                prior_d   = pulse_q;
                delta_d   = pulse_q - prior_q;
                pos_neg_d = pulse_q[CW-1];
                pos_mag_d = pulse_q[CW-1] ? (~pulse_q + CW'(1)) : pulse_q;
                den_d     = DEN_W'(cpr_q) * DEN_W'(period);
                state_d   = ST_POS_LOAD;
              end else begin
                out_load = 1'b1;
              end
            end
            OP_ZERO: begin
              pulse_d   = '0;
              prior_d   = '0;
              pos_d     = '0;
              vel_d     = '0;
              last_ab_d = '0;
              primed_d  = 1'b0;
              out_load  = 1'b1;
            end
            default: out_load = 1'b1;
          endcase
        end
      end
      ST_POS_LOAD: begin
        // Launch the position division; take the delta magnitude meanwhile
        div_start = 1'b1;
        vel_neg_d = delta_q[CW-1];
        dmag_d    = delta_q[CW-1] ? (~delta_q + CW'(1)) : delta_q;
        state_d   = ST_POS_RUN;
      end
      ST_POS_RUN: begin
        if (div_done) begin
          pos_d   = div_result;
          state_d = ST_VEL_MUL;
        end
      end
      ST_VEL_MUL: begin
        vprod_d = ProdW'(dmag_q) * ProdW'(VEL_SCALE);
        state_d = ST_VEL_LOAD;
      end
      ST_VEL_LOAD: begin
        div_start    = 1'b1;
        div_dividend = DivW'({vprod_q, {VEL_SHIFT{1'b0}}}) + DivW'(den_q >> 1);
        div_divisor  = den_q;
        div_neg      = vel_neg_q;
        state_d      = ST_VEL_RUN;
      end
      ST_VEL_RUN: begin
        div_divisor = den_q;
        div_neg     = vel_neg_q;
        if (div_done) begin
          vel_d    = div_result;
          upd      = 1'b1;
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Shared divider for both quotients
  qpv_divider #(
    .DivW (DivW)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .neg_i      (div_neg),
    .done_o     (div_done),
    .result_o   (div_result)
  );

  // Architectural state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cpr_q     <= CPR_RESET;
      last_ab_q <= '0;
      primed_q  <= 1'b0;
      pulse_q   <= '0;
      prior_q   <= '0;
      pos_q     <= '0;
      vel_q     <= '0;
    end else begin
      state_q   <= state_d;
      last_ab_q <= last_ab_d;
      primed_q  <= primed_d;
      pulse_q   <= pulse_d;
      prior_q   <= prior_d;
      pos_q     <= pos_d;
      vel_q     <= vel_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cpr_q <= cfg_data_i;
      end
    end
  end

  // Working registers of the update sequence
  always_ff @(posedge clk_i) begin
    delta_q   <= delta_d;
    pos_mag_q <= pos_mag_d;
    pos_neg_q <= pos_neg_d;
    dmag_q    <= dmag_d;
    vel_neg_q <= vel_neg_d;
    den_q     <= den_d;
    vprod_q   <= vprod_d;
  end

  // Output register: hold the beat until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {vel_d, pos_d, COUNT_OUT_W'($signed(pulse_d))};
      out_user_q <= upd;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule
